### rtl/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int REQ_W   = 2;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 5;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// data chain commands
	localparam logic [1:0] DCMD_HOLD = 2'd0;
	localparam logic [1:0] DCMD_SHR  = 2'd1;
	localparam logic [1:0] DCMD_SHL  = 2'd2;
	localparam logic [1:0] DCMD_WR   = 2'd3;

	// read chain commands
	localparam logic [1:0] RCMD_HOLD  = 2'd0;
	localparam logic [1:0] RCMD_LOAD  = 2'd1;
	localparam logic [1:0] RCMD_SHIFT = 2'd2;

	typedef struct packed {
		logic [1:0] data_cmd;
		logic [1:0] rd_cmd;
	} cell_ctl_t;

endpackage

### rtl/rbd_cell.sv
`timescale 1ns / 1ps

module rbd_cell #(
	parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF,
	parameter int IDX_W      = 4,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  rbd_pkg::cell_ctl_t    ctl,
	input  logic [IDX_W-1:0]      wr_idx,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic [DATA_WIDTH-1:0] right_rd,
	output logic [DATA_WIDTH-1:0] data_q,
	output logic [DATA_WIDTH-1:0] rd_q
);

	always_ff @(posedge clk) begin
		unique case (ctl.data_cmd)
			rbd_pkg::DCMD_SHR: data_q <= left_data;
			rbd_pkg::DCMD_SHL: data_q <= right_data;
			rbd_pkg::DCMD_WR: begin
				if (wr_idx == IDX_W'(INDEX)) data_q <= wr_data;
			end
			default: data_q <= data_q;
		endcase
	end

	// read chain: parallel load, then walks toward cell 0
	always_ff @(posedge clk) begin
		unique case (ctl.rd_cmd)
			rbd_pkg::RCMD_LOAD:  rd_q <= data_q;
			rbd_pkg::RCMD_SHIFT: rd_q <= right_rd;
			default:             rd_q <= rd_q;
		endcase
	end

endmodule

### rtl/ring_buffer_deque.sv
`timescale 1ns / 1ps

// channel | valid    | ready     | payload
// request | in_valid | in_ready  | req_type, push_value
// result  | out_valid| out_ready | pop_value, status, occupancy
//
// Elements sit left-justified in a row of cells, front in cell 0.
// Push front/back, pop front and refusals register their result on acceptance.
// Pop back walks the tail down the read chain toward cell 0, with in_ready
// low while the chain walks.
// arst_n clears count, state and result valid; cell contents are not reset.
// A waiting result holds off new requests only while out_ready is low.

module ring_buffer_deque #(
	parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rbd_pkg::REQ_W-1:0]    req_type,
	input  logic [rbd_pkg::VALUE_W-1:0]  push_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rbd_pkg::VALUE_W-1:0]  pop_value,
	output logic [rbd_pkg::STAT_W-1:0]   status,
	output logic [rbd_pkg::OCC_W-1:0]    occupancy
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SEEK = 1'b1;

	logic                  state_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      seek_q;
	logic                  out_valid_q;
	logic [rbd_pkg::VALUE_W-1:0] pop_value_q;
	logic [rbd_pkg::STAT_W-1:0]  status_q;
	logic [rbd_pkg::OCC_W-1:0]   occupancy_q;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
	logic [DATA_WIDTH-1:0] wr_data;

	rbd_pkg::cell_ctl_t    ctl;
	logic                  out_free;
	logic                  accept;
	logic                  out_load;
	logic [rbd_pkg::VALUE_W-1:0] out_value;
	logic [rbd_pkg::STAT_W-1:0]  out_status;
	logic [CNT_W-1:0]      count_d;
	logic                  state_d;
	logic [IDX_W-1:0]      seek_d;
	logic                  full;
	logic                  empty;

	assign wr_data  = DATA_WIDTH'(push_value);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ctl.data_cmd = rbd_pkg::DCMD_HOLD;
		ctl.rd_cmd   = rbd_pkg::RCMD_HOLD;
		out_load     = 1'b0;
		out_value    = '0;
		out_status   = rbd_pkg::ST_DONE;
		count_d      = count_q;
		state_d      = state_q;
		seek_d       = seek_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					out_load = 1'b1;
					case (req_type)
						rbd_pkg::REQ_PUSH_FRONT, rbd_pkg::REQ_PUSH_BACK: begin
							if (full) begin
								out_status = rbd_pkg::ST_FULL;
							end else begin
								ctl.data_cmd = (req_type == rbd_pkg::REQ_PUSH_FRONT) ?
									rbd_pkg::DCMD_SHR : rbd_pkg::DCMD_WR;
								count_d = count_q + CNT_W'(1);
							end
						end
						rbd_pkg::REQ_POP_FRONT: begin
							if (empty) begin
								out_status = rbd_pkg::ST_EMPTY;
							end else begin
								ctl.data_cmd = rbd_pkg::DCMD_SHL;
								out_value    = rbd_pkg::VALUE_W'(cell_data[0]);
								count_d      = count_q - CNT_W'(1);
							end
						end
						default: begin
							if (empty) begin
								out_status = rbd_pkg::ST_EMPTY;
							end else begin
								// tail is reported once the read chain brings it to cell 0
								out_load   = 1'b0;
								ctl.rd_cmd = rbd_pkg::RCMD_LOAD;
								count_d    = count_q - CNT_W'(1);
								seek_d     = IDX_W'(count_q - CNT_W'(1));
								state_d    = ST_SEEK;
							end
						end
					endcase
				end
			end
			default: begin
				if (seek_q != '0) begin
					ctl.rd_cmd = rbd_pkg::RCMD_SHIFT;
					seek_d     = seek_q - IDX_W'(1);
				end else if (out_free) begin
					out_load  = 1'b1;
					out_value = rbd_pkg::VALUE_W'(cell_rd[0]);
					state_d   = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			seek_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			seek_q  <= seek_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pop_value_q <= out_value;
			status_q    <= out_status;
			occupancy_q <= rbd_pkg::OCC_W'(count_d);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;
		logic [DATA_WIDTH-1:0] right_rd;

		if (i == 0) begin : g_first
			assign left_data = wr_data;
		end else begin : g_mid
			assign left_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
			assign right_rd   = '0;
		end else begin : g_inner
			assign right_data = cell_data[i+1];
			assign right_rd   = cell_rd[i+1];
		end

		rbd_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX_W      (IDX_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.wr_idx     (count_q[IDX_W-1:0]),
			.wr_data    (wr_data),
			.left_data  (left_data),
			.right_data (right_data),
			.right_rd   (right_rd),
			.data_q     (cell_data[i]),
			.rd_q       (cell_rd[i])
		);
	end

	assign out_valid = out_valid_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count beyond depth");

	a_seek_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEEK |-> !in_ready)
		else $error("request taken during tail seek");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == rbd_pkg::ST_FULL |->
		occupancy_q == rbd_pkg::OCC_W'(DEPTH))
		else $error("full refusal with wrong occupancy");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == rbd_pkg::ST_EMPTY |->
		occupancy_q == '0 && pop_value_q == '0)
		else $error("empty refusal with wrong result");

endmodule
